@@ rtl/core/ssd_pkg.sv @@
// shared types and constants for the sorted set scan differ
package ssd_pkg;

    localparam int SET_DEPTH = 32;
    localparam int ID_W      = 32;
    localparam int KIND_W    = 2;
    localparam int CNT_W     = $clog2(SET_DEPTH + 1);
    localparam int ODATA_W   = ((ID_W + 7) / 8) * 8;
    localparam int OUSER_W   = KIND_W + 1;

    localparam logic OP_INSERT   = 1'b0;
    localparam logic OP_END_SCAN = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_OPEN  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_NONE  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MERGE,
        S_FINAL,
        S_RESTORE
    } t_state;

    typedef struct packed {
        logic ins_en;
        logic shift_prev;
        logic rot_cur;
        logic commit;
    } t_cell_ctl;

endpackage

@@ rtl/core/sorted_set_scan_differ_core.sv @@
// top level of the sorted set scan differ: cell row, merge sequencer, output stage
//
// An insert transfer is taken and applied at once: every cell compares the new identifier
// with its entry at once and the row opens a gap at the sorted place. An end-of-scan
// transfer starts a merge in which cell 0 compares the heads of the previous and the
// current row, one step per cycle unless the result side stalls, the previous row
// shifting out and the current row rotating through all cells. The input is then held
// off while the merge takes one step per distinct identifier, sees both rows used up,
// marks the last result, makes the remaining rotations that bring the current row back
// to its order and commits, longer when the result side stalls. Results leave through a
// one-deep output register, held one step behind so that the last one can be marked.
module sorted_set_scan_differ_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [ssd_pkg::ID_W-1:0]    i_s_tdata,   // item_id
    input  logic                       i_s_tuser,   // opcode
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [ssd_pkg::ODATA_W-1:0] o_m_tdata,   // event_id
    output logic                       o_m_tlast,   // last_event
    output logic [ssd_pkg::OUSER_W-1:0] o_m_tuser    // event_kind, set_overflowed
);
    import ssd_pkg::*;

    t_state          r_state, n_state;
    t_cell_ctl       ctl;

    logic [CNT_W-1:0] r_cur_cnt, r_prev_cnt, r_a_rem, r_b_rem, r_rot;
    logic             r_ovf;

    logic             r_pend_v;
    t_kind            r_pend_kind;
    logic [ID_W-1:0]  r_pend_id;

    logic             r_ov;
    t_kind            r_o_kind;
    logic [ID_W-1:0]  r_o_id;
    logic             r_o_last;
    logic             r_o_ovf;

    logic [SET_DEPTH-1:0] lt_vec, eq_vec, valid_vec;
    logic [ID_W-1:0]      cur_q  [SET_DEPTH];
    logic [ID_W-1:0]      prev_q [SET_DEPTH];

    logic s_fire, out_free, dup, full;
    logic a_any, b_any, pick_close, pick_open, pick_skip, step_ok;
    logic push, push_last, pend_set, pend_clr;
    t_kind push_kind, new_kind;
    logic [ID_W-1:0] push_id, new_id;
    logic a_dec, b_dec, rot_inc, load_rem, ovf_set;

    // cell row
    for (genvar g = 0; g < SET_DEPTH; g++) begin : g_cell
        localparam int RIGHT = (g == SET_DEPTH - 1) ? 0 : g + 1;
        localparam int LEFT  = (g == 0) ? 0 : g - 1;
        logic left_lt;

        assign valid_vec[g] = CNT_W'(g) < r_cur_cnt;
        assign left_lt      = (g == 0) ? 1'b1 : lt_vec[LEFT];

        ssd_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_id         (i_s_tdata),
            .i_valid      (valid_vec[g]),
            .i_left_lt    (left_lt),
            .i_left_cur   (cur_q[LEFT]),
            .i_right_cur  (cur_q[RIGHT]),
            .i_right_prev (prev_q[RIGHT]),
            .o_lt         (lt_vec[g]),
            .o_eq         (eq_vec[g]),
            .o_cur        (cur_q[g]),
            .o_prev       (prev_q[g])
        );
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_ov || i_m_tready;
    assign dup        = |eq_vec;
    assign full       = (r_cur_cnt == CNT_W'(SET_DEPTH));

    // head compare in cell 0
    assign a_any      = (r_a_rem != '0);
    assign b_any      = (r_b_rem != '0);
    assign pick_close = a_any && (!b_any || (prev_q[0] < cur_q[0]));
    assign pick_open  = b_any && (!a_any || (cur_q[0] < prev_q[0]));
    assign pick_skip  = a_any && b_any && (prev_q[0] == cur_q[0]);
    assign step_ok    = pick_skip || !r_pend_v || out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_fire && (i_s_tuser == OP_END_SCAN)) begin
                    n_state = S_MERGE;
                end
            end
            S_MERGE: begin
                if (!a_any && !b_any) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                if (out_free) begin
                    n_state = S_RESTORE;
                end
            end
            S_RESTORE: begin
                if (r_rot == CNT_W'(SET_DEPTH)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ctl       = '0;
        push      = 1'b0;
        push_last = 1'b0;
        push_kind = KIND_NONE;
        push_id   = '0;
        pend_set  = 1'b0;
        pend_clr  = 1'b0;
        new_kind  = KIND_NONE;
        new_id    = '0;
        a_dec     = 1'b0;
        b_dec     = 1'b0;
        rot_inc   = 1'b0;
        load_rem  = 1'b0;
        ovf_set   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (s_fire && (i_s_tuser == OP_INSERT) && !dup) begin
                    ctl.ins_en = !full;
                    ovf_set    = full;
                end
                load_rem = s_fire && (i_s_tuser == OP_END_SCAN);
            end
            S_MERGE: begin
                if ((a_any || b_any) && step_ok) begin
                    if (pick_skip) begin
                        ctl.shift_prev = 1'b1;
                        ctl.rot_cur    = 1'b1;
                        a_dec          = 1'b1;
                        b_dec          = 1'b1;
                        rot_inc        = 1'b1;
                    end else begin
                        pend_set  = 1'b1;
                        push      = r_pend_v;
                        push_kind = r_pend_kind;
                        push_id   = r_pend_id;
                        if (pick_close) begin
                            ctl.shift_prev = 1'b1;
                            a_dec          = 1'b1;
                            new_kind       = KIND_CLOSE;
                            new_id         = prev_q[0];
                        end else if (pick_open) begin
                            ctl.rot_cur = 1'b1;
                            b_dec       = 1'b1;
                            rot_inc     = 1'b1;
                            new_kind    = KIND_OPEN;
                            new_id      = cur_q[0];
                        end
                    end
                end
            end
            S_FINAL: begin
                if (out_free) begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    pend_clr  = 1'b1;
                    if (r_pend_v) begin
                        push_kind = r_pend_kind;
                        push_id   = r_pend_id;
                    end
                end
            end
            S_RESTORE: begin
                if (r_rot == CNT_W'(SET_DEPTH)) begin
                    ctl.commit = 1'b1;
                end else begin
                    ctl.rot_cur = 1'b1;
                    rot_inc     = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cur_cnt  <= '0;
            r_prev_cnt <= '0;
            r_ovf      <= 1'b0;
            r_pend_v   <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ctl.ins_en) begin
                r_cur_cnt <= r_cur_cnt + CNT_W'(1);
            end else if (ctl.commit) begin
                r_cur_cnt <= '0;
            end
            if (ctl.commit) begin
                r_prev_cnt <= r_cur_cnt;
            end
            if (ctl.commit) begin
                r_ovf <= 1'b0;
            end else if (ovf_set) begin
                r_ovf <= 1'b1;
            end
            if (pend_set) begin
                r_pend_v <= 1'b1;
            end else if (pend_clr) begin
                r_pend_v <= 1'b0;
            end
            if (push) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_rem) begin
            r_a_rem <= r_prev_cnt;
            r_b_rem <= r_cur_cnt;
            r_rot   <= '0;
        end else begin
            if (a_dec) begin
                r_a_rem <= r_a_rem - CNT_W'(1);
            end
            if (b_dec) begin
                r_b_rem <= r_b_rem - CNT_W'(1);
            end
            if (rot_inc) begin
                r_rot <= r_rot + CNT_W'(1);
            end
        end
        if (pend_set) begin
            r_pend_kind <= new_kind;
            r_pend_id   <= new_id;
        end
        if (push) begin
            r_o_kind <= push_kind;
            r_o_id   <= push_id;
            r_o_last <= push_last;
            r_o_ovf  <= r_ovf;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = ODATA_W'(r_o_id);
    assign o_m_tlast  = r_o_last;
    assign o_m_tuser  = {r_o_ovf, r_o_kind};

endmodule

@@ rtl/core/ssd_cell.sv @@
// one cell of the set row: one previous-set entry and one current-set entry
module ssd_cell (
    input  logic                    i_clk,
    input  ssd_pkg::t_cell_ctl      i_ctl,
    input  logic [ssd_pkg::ID_W-1:0] i_id,
    input  logic                    i_valid,
    input  logic                    i_left_lt,
    input  logic [ssd_pkg::ID_W-1:0] i_left_cur,
    input  logic [ssd_pkg::ID_W-1:0] i_right_cur,
    input  logic [ssd_pkg::ID_W-1:0] i_right_prev,
    output logic                    o_lt,
    output logic                    o_eq,
    output logic [ssd_pkg::ID_W-1:0] o_cur,
    output logic [ssd_pkg::ID_W-1:0] o_prev
);
    import ssd_pkg::*;

    logic [ID_W-1:0] r_cur;
    logic [ID_W-1:0] r_prev;

    assign o_lt   = i_valid && (r_cur < i_id);
    assign o_eq   = i_valid && (r_cur == i_id);
    assign o_cur  = r_cur;
    assign o_prev = r_prev;

    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            r_prev <= r_cur;
        end else if (i_ctl.shift_prev) begin
            r_prev <= i_right_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins_en) begin
            if (!o_lt) begin
                r_cur <= i_left_lt ? i_id : i_left_cur;
            end
        end else if (i_ctl.rot_cur) begin
            r_cur <= i_right_cur;
        end
    end

endmodule

@@ sim/testbench.sv @@
// testbench for the sorted set scan differ: directed and random scans checked against a predictor
module testbench;
    import ssd_pkg::*;

    typedef struct {
        t_kind             kind;
        logic [ID_W-1:0]   id;
        logic              last;
        logic              ovf;
    } t_scan_event;

    localparam int   TARGET_ITEMS = 480;
    localparam int   SETTLE_CYCLES = 2 * SET_DEPTH + 16;

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic [ID_W-1:0]    s_tdata   = '0;
    logic               s_tuser   = 1'b0;
    logic               m_tready  = 1'b0;
    logic               s_tready;
    logic               m_tvalid;
    logic [ODATA_W-1:0] m_tdata;
    logic               m_tlast;
    logic [OUSER_W-1:0] m_tuser;

    // predictor state
    logic [ID_W-1:0] prev_ids[$];
    logic [ID_W-1:0] cur_ids[$];
    logic            dropped_insert;
    t_scan_event     pending_events[$];

    int items_sent     = 0;
    int scans_ended    = 0;
    int overflow_scans = 0;
    int events_checked = 0;
    int error_count    = 0;

    // sender pacing
    int tx_burst_left = 0;
    int tx_gap_max    = 0;

    // receiver pacing
    int rx_mode       = 0;
    int rx_stall_pct  = 0;
    int rx_hold_req   = 0;

    sorted_set_scan_differ_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #6_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic track_insert(input logic [ID_W-1:0] id);
        int pos;
        pos = 0;
        while (pos < cur_ids.size() && cur_ids[pos] < id) pos++;
        if (pos < cur_ids.size() && cur_ids[pos] == id) return;
        if (cur_ids.size() >= SET_DEPTH) begin
            dropped_insert = 1'b1;
            return;
        end
        cur_ids.insert(pos, id);
    endtask

    task automatic diff_scan_sets();
        t_scan_event burst[$];
        t_scan_event ev;
        int a;
        int b;
        a = 0;
        b = 0;
        ev.last = 1'b0;
        ev.ovf  = dropped_insert;
        while (a < prev_ids.size() || b < cur_ids.size()) begin
            if (b >= cur_ids.size() || (a < prev_ids.size() && prev_ids[a] < cur_ids[b])) begin
                ev.kind = KIND_CLOSE;
                ev.id   = prev_ids[a];
                burst.push_back(ev);
                a++;
            end else if (a >= prev_ids.size() || prev_ids[a] > cur_ids[b]) begin
                ev.kind = KIND_OPEN;
                ev.id   = cur_ids[b];
                burst.push_back(ev);
                b++;
            end else begin
                a++;
                b++;
            end
        end
        if (burst.size() == 0) begin
            ev.kind = KIND_NONE;
            ev.id   = '0;
            burst.push_back(ev);
        end
        burst[burst.size() - 1].last = 1'b1;
        foreach (burst[i]) pending_events.push_back(burst[i]);
        if (dropped_insert) overflow_scans++;
        scans_ended++;
        prev_ids = cur_ids;
        cur_ids.delete();
        dropped_insert = 1'b0;
    endtask

    // one item: idles between bursts, then waits for the transfer
    task automatic send_item(input logic op, input logic [ID_W-1:0] id);
        int gap;
        if (tx_burst_left == 0) begin
            tx_burst_left = $urandom_range(1, 16);
            gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= id;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        items_sent++;
        tx_burst_left--;
        if (op == OP_INSERT) track_insert(id);
        else diff_scan_sets();
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        tx_burst_left = 0;
        @(posedge i_clk);
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30 && prev_ids.size() != 0)
            return prev_ids[$urandom_range(0, prev_ids.size() - 1)];
        if (r < 40 && cur_ids.size() != 0)
            return cur_ids[$urandom_range(0, cur_ids.size() - 1)];
        if (r < 60) return $urandom_range(0, 15);
        if (r < 66) return 32'hFFFF_FFFF - $urandom_range(0, 3);
        if (r < 70) return 32'h8000_0000 + $urandom_range(0, 3) - 2;
        return $urandom;
    endfunction

    task automatic test_directed();
        send_item(OP_END_SCAN, 32'h0);
        send_item(OP_INSERT, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 32'h0000_0000);
        send_item(OP_INSERT, 32'h8000_0000);
        send_item(OP_INSERT, 32'h7FFF_FFFF);
        send_item(OP_INSERT, 32'h0000_0001);
        send_item(OP_INSERT, 32'h0000_0000);
        send_item(OP_INSERT, 32'hFFFF_FFFF);
        send_item(OP_END_SCAN, 32'hDEAD_BEEF);
        send_item(OP_INSERT, 32'h0000_0001);
        send_item(OP_INSERT, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 32'h0000_0000);
        send_item(OP_INSERT, 32'h8000_0000);
        send_item(OP_INSERT, 32'h7FFF_FFFF);
        send_item(OP_END_SCAN, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 32'h0000_0000);
        send_item(OP_INSERT, 32'h0000_0005);
        send_item(OP_INSERT, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 32'h8000_0001);
        send_item(OP_END_SCAN, 32'h0);
        send_item(OP_END_SCAN, 32'h0);
        wait_drain();
    endtask

    task automatic test_full_set();
        // fill exactly, then a duplicate of a stored entry must not flag
        while (cur_ids.size() < SET_DEPTH) send_item(OP_INSERT, $urandom);
        send_item(OP_INSERT, cur_ids[$urandom_range(0, SET_DEPTH - 1)]);
        send_item(OP_END_SCAN, 32'h0);
        // disjoint full set plus dropped inserts gives the longest burst
        while (cur_ids.size() < SET_DEPTH) send_item(OP_INSERT, $urandom);
        send_item(OP_INSERT, cur_ids[0]);
        repeat (3) send_item(OP_INSERT, $urandom);
        send_item(OP_INSERT, cur_ids[SET_DEPTH - 1]);
        send_item(OP_END_SCAN, 32'h0);
        send_item(OP_END_SCAN, 32'h0);
        wait_drain();
    endtask

    task automatic test_backpressure();
        tx_gap_max = 0;
        rx_hold_req = 400;
        repeat (4) begin
            repeat ($urandom_range(4, 12)) send_item(OP_INSERT, pick_id());
            send_item(OP_END_SCAN, $urandom);
        end
        wait_drain();
    endtask

    task automatic test_random_scans();
        int r;
        int set_size;
        int scan_no;
        scan_no = 0;
        while (items_sent < TARGET_ITEMS) begin
            if (scan_no % 8 == 0) begin
                r = $urandom_range(0, 2);
                tx_gap_max = (r == 0) ? 0 : (r == 1) ? 4 : 12;
                rx_mode = $urandom_range(0, 2);
                rx_stall_pct = $urandom_range(10, 60);
            end
            r = $urandom_range(0, 99);
            if (r < 8)       set_size = 0;
            else if (r < 80) set_size = $urandom_range(1, 8);
            else if (r < 93) set_size = $urandom_range(9, 20);
            else             set_size = $urandom_range(30, 40);
            repeat (set_size) begin
                // noise: an occasional scan end in the middle of a sequence
                if ($urandom_range(0, 99) < 3) send_item(OP_END_SCAN, $urandom);
                send_item(OP_INSERT, pick_id());
            end
            send_item(OP_END_SCAN, $urandom);
            if ($urandom_range(0, 99) < 10) wait_drain();
            scan_no++;
        end
        wait_drain();
    endtask

    // receiver stall pattern, with a long hold-off on request
    initial begin
        int hold_left;
        int cyc;
        hold_left = 0;
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (rx_hold_req > 0) begin
                hold_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_mode == 1) begin
                m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end else if (rx_mode == 2) begin
                m_tready <= ((cyc % 7) < 4);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // result checker
    initial begin
        t_scan_event exp_ev;
        t_kind       got_kind;
        logic [ID_W-1:0] got_id;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_tvalid && m_tready) begin
                got_kind = t_kind'(m_tuser[KIND_W-1:0]);
                got_id   = m_tdata[ID_W-1:0];
                events_checked++;
                if (pending_events.size() == 0) begin
                    $display("%0t: unexpected transfer kind %0d id %h", $time, got_kind, got_id);
                    error_count++;
                end else begin
                    exp_ev = pending_events.pop_front();
                    if (got_kind !== exp_ev.kind) begin
                        $display("%0t: event_kind expected %0d actual %0d",
                                 $time, exp_ev.kind, got_kind);
                        error_count++;
                    end
                    if (got_id !== exp_ev.id) begin
                        $display("%0t: event_id expected %h actual %h", $time, exp_ev.id, got_id);
                        error_count++;
                    end
                    if (m_tlast !== exp_ev.last) begin
                        $display("%0t: last_event expected %b actual %b",
                                 $time, exp_ev.last, m_tlast);
                        error_count++;
                    end
                    if (m_tuser[KIND_W] !== exp_ev.ovf) begin
                        $display("%0t: set_overflowed expected %b actual %b",
                                 $time, exp_ev.ovf, m_tuser[KIND_W]);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin
        dropped_insert = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_set();
        test_backpressure();
        test_random_scans();
        if (pending_events.size() != 0) begin
            $display("%0t: %0d expected events never arrived", $time, pending_events.size());
            error_count++;
        end
        $display("run covered %0d input items and %0d scan ends, %0d of them with dropped inserts",
                 items_sent, scans_ended, overflow_scans);
        $display("%0d events compared, %0d mismatches", events_checked, error_count);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
